/* sv/mrcsm_pkg.sv */
// ============================================================================
// mrcsm_pkg: shared types and constants for the matrix row/column sum block
// Field widths of the item channels, register indexes and result kinds.
// ============================================================================
package mrcsm_pkg;

    // Item field widths.
    localparam int ELEM_W     = 16;
    localparam int SUM_W      = 22;
    localparam int IDX_W      = 6;
    localparam int MROW_W     = 6;
    localparam int MCOL_W     = 4;
    localparam int KIND_W     = 2;

    // Configuration port.
    localparam int NUM_ROWS_W = 7;
    localparam int NUM_COLS_W = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // Register values after reset.
    localparam int NUM_ROWS_RST = 64;
    localparam int NUM_COLS_RST = 16;

    // Kind of a result item.
    typedef enum logic [KIND_W-1:0] {
        KIND_ROW = 2'd0,
        KIND_COL = 2'd1,
        KIND_MAX = 2'd2
    } result_kind_t;

    // Commands to the column sum memory.
    typedef struct packed {
        logic add;    // accumulate an element into the addressed column
        logic rd;     // read the addressed column sum for output
        logic clear;  // start a new matrix: all column sums read as zero
    } cm_ctl_t;

endpackage

/* sv/mrcsm_if.sv */
// ============================================================================
// mrcsm_if: item channels of the matrix row/column sum block
// Element channel and result channel, each with valid/ready handshake.
// ============================================================================
interface mrcsm_elem_if;
    import mrcsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] elem_value;

    modport source (output valid, output elem_value, input ready);
    modport sink   (input valid, input elem_value, output ready);
endinterface

interface mrcsm_result_if;
    import mrcsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [IDX_W-1:0]  result_index;
    logic [SUM_W-1:0]  sum_value;
    logic [ELEM_W-1:0] max_value;
    logic [MROW_W-1:0] max_row;
    logic [MCOL_W-1:0] max_col;
    logic              last;

    modport source (output valid, output result_kind, output result_index,
                    output sum_value, output max_value, output max_row,
                    output max_col, output last, input ready);
    modport sink   (input valid, input result_kind, input result_index,
                    input sum_value, input max_value, input max_row,
                    input max_col, input last, output ready);
endinterface

/* sv/mrcsm_colmem.sv */
// ============================================================================
// mrcsm_colmem: column sum memory with read-modify-write
// One synchronous memory holds the per-column sums. An element is added in
// two steps: the column is read at acceptance and written back in the next
// cycle. The last write is forwarded to cover a read at the same edge.
// ============================================================================
module mrcsm_colmem #(
    parameter int COLS = 16,
    parameter int AW   = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mrcsm_pkg::cm_ctl_t           ctl,
    input  logic [AW-1:0]                addr,
    input  logic [mrcsm_pkg::ELEM_W-1:0] value,
    output logic                         busy,
    output logic [mrcsm_pkg::SUM_W-1:0]  rd_sum
);
    import mrcsm_pkg::*;

    logic [SUM_W-1:0]  mem [COLS];
    logic [SUM_W-1:0]  rd_data_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [COLS-1:0]   col_vld_reg;
    logic              b_vld_reg;
    logic [ELEM_W-1:0] b_val_reg;
    logic              wr_vld_reg;
    logic [AW-1:0]     wr_col_reg;
    logic [SUM_W-1:0]  wr_data_reg;
    logic              fwd;
    logic [SUM_W-1:0]  new_sum;

    // Current value of the column read last: forwarded write, stored sum,
    // or zero for a column not yet written in this matrix.
    always_comb
    begin
        fwd = wr_vld_reg && (wr_col_reg == rd_addr_reg);
        if (fwd)
        begin
            rd_sum = wr_data_reg;
        end
        else if (col_vld_reg[rd_addr_reg])
        begin
            rd_sum = rd_data_reg;
        end
        else
        begin
            rd_sum = '0;
        end
        new_sum = rd_sum + SUM_W'(b_val_reg);
    end

    assign busy = b_vld_reg;

    // Memory array: one read port, one write port.
    always_ff @(posedge clk)
    begin
        if (ctl.add || ctl.rd)
        begin
            rd_data_reg <= mem[addr];
        end
        if (b_vld_reg)
        begin
            mem[rd_addr_reg] <= new_sum;
        end
    end

    // Address and write-back payload.
    always_ff @(posedge clk)
    begin
        if (ctl.add || ctl.rd)
        begin
            rd_addr_reg <= addr;
        end
        if (ctl.add)
        begin
            b_val_reg <= value;
        end
        if (b_vld_reg)
        begin
            wr_col_reg  <= rd_addr_reg;
            wr_data_reg <= new_sum;
        end
    end

    // Valid bits and pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg <= '0;
            b_vld_reg   <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            col_vld_reg <= '0;
            b_vld_reg   <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end
        else
        begin
            b_vld_reg <= ctl.add;
            if (b_vld_reg)
            begin
                col_vld_reg[rd_addr_reg] <= 1'b1;
                wr_vld_reg               <= 1'b1;
            end
        end
    end

endmodule

/* sv/matrix_row_col_sum_max.sv */
// ============================================================================
// matrix_row_col_sum_max: row/column sums and first global maximum
// Top level: position counters, row accumulators, global maximum, result
// register and the drain sequencer for the column sums.
// ============================================================================
// Elements arrive in row-major order, one per cycle while the result register
// is free; the last element of a row also loads that row's sum and maximum.
// Column sums live in a synchronous memory with one read and one write port,
// updated by read-modify-write. After the last element of the matrix no
// element is taken until the column sums and the global maximum have been
// sent: the pending write-back completes, each column is read and then
// output in turn, and the maximum is sent last. Writing either size
// register restarts the matrix.
module matrix_row_col_sum_max #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mrcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrcsm_pkg::CFG_DATA_W-1:0] cfg_data,
    mrcsm_elem_if.sink                       elem,
    mrcsm_result_if.source                   result
);
    import mrcsm_pkg::*;

    localparam int RPW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CPW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWS_RST = (NUM_ROWS_RST > MAX_ROWS) ? MAX_ROWS : NUM_ROWS_RST;
    localparam int COLS_RST = (NUM_COLS_RST > MAX_COLS) ? MAX_COLS : NUM_COLS_RST;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRD,
        ST_DOUT,
        ST_DMAX
    } state_t;

    state_t            state_reg, state_next;
    logic [RPW-1:0]    last_row_reg, last_row_next;
    logic [CPW-1:0]    last_col_reg, last_col_next;
    logic [RPW-1:0]    row_pos_reg, row_pos_next;
    logic [CPW-1:0]    col_pos_reg, col_pos_next;
    logic [CPW-1:0]    drain_reg, drain_next;
    logic [SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [ELEM_W-1:0] row_max_reg, row_max_next;
    logic [ELEM_W-1:0] best_val_reg, best_val_next;
    logic [RPW-1:0]    best_row_reg, best_row_next;
    logic [CPW-1:0]    best_col_reg, best_col_next;

    logic              out_vld_reg, out_vld_next;
    result_kind_t      out_kind_reg, out_kind_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic [ELEM_W-1:0] out_max_reg, out_max_next;
    logic [MROW_W-1:0] out_mrow_reg, out_mrow_next;
    logic [MCOL_W-1:0] out_mcol_reg, out_mcol_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              cfg_hit;
    logic [31:0]       rows_req;
    logic [31:0]       cols_req;
    logic [SUM_W-1:0]  row_sum_add;
    logic [ELEM_W-1:0] row_max_upd;
    cm_ctl_t           cm_ctl;
    logic [CPW-1:0]    cm_addr;
    logic              cm_busy;
    logic [SUM_W-1:0]  cm_sum;

    // Handshake.
    assign out_free    = !out_vld_reg || result.ready;
    assign elem.ready  = (state_reg == ST_RUN) && out_free;
    assign accept      = elem.valid && elem.ready;
    assign cfg_hit     = cfg_we && ((cfg_index == REG_NUM_ROWS) ||
                                    (cfg_index == REG_NUM_COLS));

    // Effective size from a register write: zero counts as one, large values
    // are limited to the build maximum.
    assign rows_req = 32'(cfg_data[NUM_ROWS_W-1:0]);
    assign cols_req = 32'(cfg_data[NUM_COLS_W-1:0]);

    assign row_sum_add = row_sum_reg + SUM_W'(elem.elem_value);
    assign row_max_upd = (elem.elem_value > row_max_reg) ? elem.elem_value
                                                         : row_max_reg;

    // Column sum memory requests.
    always_comb
    begin
        cm_ctl.add   = accept;
        cm_ctl.rd    = (state_reg == ST_DRD) && !cm_busy;
        cm_ctl.clear = cfg_hit || ((state_reg == ST_DMAX) && out_free);
        cm_addr      = (state_reg == ST_RUN) ? col_pos_reg : drain_reg;
    end

    // Next state of the sequencer, accumulators and result register.
    always_comb
    begin
        state_next    = state_reg;
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        drain_next    = drain_reg;
        row_sum_next  = row_sum_reg;
        row_max_next  = row_max_reg;
        best_val_next = best_val_reg;
        best_row_next = best_row_reg;
        best_col_next = best_col_reg;
        out_vld_next  = out_vld_reg && !result.ready;
        out_kind_next = out_kind_reg;
        out_idx_next  = out_idx_reg;
        out_sum_next  = out_sum_reg;
        out_max_next  = out_max_reg;
        out_mrow_next = out_mrow_reg;
        out_mcol_next = out_mcol_reg;
        out_last_next = out_last_reg;

        if (cfg_hit)
        begin
            // Size change restarts the matrix.
            if (cfg_index == REG_NUM_ROWS)
            begin
                if (rows_req == 32'd0)
                begin
                    last_row_next = '0;
                end
                else if (rows_req > 32'(MAX_ROWS))
                begin
                    last_row_next = RPW'(MAX_ROWS - 1);
                end
                else
                begin
                    last_row_next = RPW'(rows_req - 32'd1);
                end
            end
            else
            begin
                if (cols_req == 32'd0)
                begin
                    last_col_next = '0;
                end
                else if (cols_req > 32'(MAX_COLS))
                begin
                    last_col_next = CPW'(MAX_COLS - 1);
                end
                else
                begin
                    last_col_next = CPW'(cols_req - 32'd1);
                end
            end
            state_next    = ST_RUN;
            row_pos_next  = '0;
            col_pos_next  = '0;
            drain_next    = '0;
            row_sum_next  = '0;
            row_max_next  = '0;
            best_val_next = '0;
            best_row_next = '0;
            best_col_next = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (accept)
                    begin
                        // Global maximum: first element taken as is, later
                        // ones only when strictly greater.
                        if ((row_pos_reg == '0) && (col_pos_reg == '0))
                        begin
                            best_val_next = elem.elem_value;
                            best_row_next = '0;
                            best_col_next = '0;
                        end
                        else if (elem.elem_value > best_val_reg)
                        begin
                            best_val_next = elem.elem_value;
                            best_row_next = row_pos_reg;
                            best_col_next = col_pos_reg;
                        end

                        if (col_pos_reg == last_col_reg)
                        begin
                            // End of row: send the row result.
                            out_vld_next  = 1'b1;
                            out_kind_next = KIND_ROW;
                            out_idx_next  = IDX_W'(row_pos_reg);
                            out_sum_next  = row_sum_add;
                            out_max_next  = row_max_upd;
                            out_mrow_next = '0;
                            out_mcol_next = '0;
                            out_last_next = 1'b0;
                            row_sum_next  = '0;
                            row_max_next  = '0;
                            col_pos_next  = '0;
                            if (row_pos_reg == last_row_reg)
                            begin
                                drain_next = '0;
                                state_next = ST_DRD;
                            end
                            else
                            begin
                                row_pos_next = row_pos_reg + RPW'(1);
                            end
                        end
                        else
                        begin
                            row_sum_next = row_sum_add;
                            row_max_next = row_max_upd;
                            col_pos_next = col_pos_reg + CPW'(1);
                        end
                    end
                end

                ST_DRD:
                begin
                    // Read the column once the last write-back is done.
                    if (!cm_busy)
                    begin
                        state_next = ST_DOUT;
                    end
                end

                ST_DOUT:
                begin
                    if (out_free)
                    begin
                        out_vld_next  = 1'b1;
                        out_kind_next = KIND_COL;
                        out_idx_next  = IDX_W'(drain_reg);
                        out_sum_next  = cm_sum;
                        out_max_next  = '0;
                        out_mrow_next = '0;
                        out_mcol_next = '0;
                        out_last_next = 1'b0;
                        if (drain_reg == last_col_reg)
                        begin
                            state_next = ST_DMAX;
                        end
                        else
                        begin
                            drain_next = drain_reg + CPW'(1);
                            state_next = ST_DRD;
                        end
                    end
                end

                ST_DMAX:
                begin
                    if (out_free)
                    begin
                        out_vld_next  = 1'b1;
                        out_kind_next = KIND_MAX;
                        out_idx_next  = '0;
                        out_sum_next  = '0;
                        out_max_next  = best_val_reg;
                        out_mrow_next = MROW_W'(best_row_reg);
                        out_mcol_next = MCOL_W'(best_col_reg);
                        out_last_next = 1'b1;
                        row_pos_next  = '0;
                        col_pos_next  = '0;
                        drain_next    = '0;
                        best_val_next = '0;
                        best_row_next = '0;
                        best_col_next = '0;
                        state_next    = ST_RUN;
                    end
                end

                default:
                begin
                    state_next = ST_RUN;
                end
            endcase
        end
    end

    // State, accumulators and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            last_row_reg <= RPW'(ROWS_RST - 1);
            last_col_reg <= CPW'(COLS_RST - 1);
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            drain_reg    <= '0;
            row_sum_reg  <= '0;
            row_max_reg  <= '0;
            best_val_reg <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
            out_vld_reg  <= 1'b0;
            out_kind_reg <= KIND_ROW;
            out_idx_reg  <= '0;
            out_sum_reg  <= '0;
            out_max_reg  <= '0;
            out_mrow_reg <= '0;
            out_mcol_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            drain_reg    <= drain_next;
            row_sum_reg  <= row_sum_next;
            row_max_reg  <= row_max_next;
            best_val_reg <= best_val_next;
            best_row_reg <= best_row_next;
            best_col_reg <= best_col_next;
            out_vld_reg  <= out_vld_next;
            out_kind_reg <= out_kind_next;
            out_idx_reg  <= out_idx_next;
            out_sum_reg  <= out_sum_next;
            out_max_reg  <= out_max_next;
            out_mrow_reg <= out_mrow_next;
            out_mcol_reg <= out_mcol_next;
            out_last_reg <= out_last_next;
        end
    end

    // Result channel.
    assign result.valid        = out_vld_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.result_index = out_idx_reg;
    assign result.sum_value    = out_sum_reg;
    assign result.max_value    = out_max_reg;
    assign result.max_row      = out_mrow_reg;
    assign result.max_col      = out_mcol_reg;
    assign result.last         = out_last_reg;

    // Column sum memory.
    mrcsm_colmem #(
        .COLS (MAX_COLS),
        .AW   (CPW)
    ) u_colmem (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cm_ctl),
        .addr   (cm_addr),
        .value  (elem.elem_value),
        .busy   (cm_busy),
        .rd_sum (cm_sum)
    );

endmodule
